// ===== design/refcounted_key_membership_table_defines.svh =====
// ----------------------------------------------------------------------------
// refcounted_key_membership_table_defines
// Assertion macros used by the key membership table RTL.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_KEY_MEMBERSHIP_TABLE_DEFINES_SVH
`define REFCOUNTED_KEY_MEMBERSHIP_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RKMT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("refcounted_key_membership_table: property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RKMT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("refcounted_key_membership_table: property failed");

`endif

// ===== design/rkmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rkmt_pkg
// Sizes, codes and shared types of the key membership table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rkmt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int REF_BITS      = 16;
    localparam int KEY_W         = 64;
    localparam int OUT_CNT_W     = 5;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W       = KEY_W + REF_BITS;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] page_dir_base;
        logic             force_req;
    } req_t;

    typedef struct packed {
        logic                 found;
        logic                 flush_request;
        logic                 table_full;
        logic [OUT_CNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
    } ram_cmd_t;

endpackage

// ===== design/rkmt_req_if.sv =====
// ----------------------------------------------------------------------------
// rkmt_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rkmt_req_if;
    import rkmt_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [KEY_W-1:0] page_dir_base;
    logic             force_req;

    modport source (output valid, mode, page_dir_base, force_req, input ready);
    modport sink   (input valid, mode, page_dir_base, force_req, output ready);
endinterface

// ===== design/rkmt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rkmt_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rkmt_rsp_if;
    import rkmt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic                 flush_request;
    logic                 table_full;
    logic [OUT_CNT_W-1:0] entry_count;

    modport source (output valid, found, flush_request, table_full, entry_count,
                    input ready);
    modport sink   (input valid, found, flush_request, table_full, entry_count,
                    output ready);
endinterface

// ===== design/rkmt_ram.sv =====
// ----------------------------------------------------------------------------
// rkmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rkmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]                               wr_data,
    input  logic                                           rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/rkmt_scan.sv =====
// ----------------------------------------------------------------------------
// rkmt_scan
// Sequencer: scans the entry RAM for the key and a free slot, then commits; a clear skips the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rkmt_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  rkmt_pkg::req_t             req,
    output logic                       req_ready,
    output rkmt_pkg::ram_cmd_t         ram_cmd,
    input  logic [rkmt_pkg::ENTRY_W-1:0] ram_rd_data,
    input  logic                       rsp_free,
    output logic                       rsp_push,
    output rkmt_pkg::rsp_t             rsp
);
    import rkmt_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]        total_reg;
    logic [CNT_W-1:0]        total_next;
    logic [CNT_W-1:0]        iss_reg;
    logic                    chk_vld_reg;
    logic [IDX_W-1:0]        chk_idx_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [REF_BITS-1:0]     hit_refs_reg;
    logic                    free_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    mode_t                   mode_reg;
    logic [KEY_W-1:0]        key_reg;
    logic                    force_reg;
    rsp_t                    rsp_reg;

    logic                    scan_done;
    logic                    key_hit;
    logic                    slot_free;
    logic [REF_BITS-1:0]     refs_inc;
    logic [REF_BITS-1:0]     refs_dec;
    logic                    wr_en_c;
    logic [IDX_W-1:0]        wr_idx_c;
    logic [REF_BITS-1:0]     wr_refs_c;
    rsp_t                    rsp_c;

    assign scan_done = (iss_reg == CNT_W'(TABLE_ENTRIES)) && chk_vld_reg;
    assign key_hit   = chk_vld_reg && valid_reg[chk_idx_reg]
                       && (ram_rd_data[ENTRY_W-1:REF_BITS] == key_reg);
    assign slot_free = chk_vld_reg && !valid_reg[chk_idx_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (mode_t'(req.mode) == MODE_CLEAR) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready       = 1'b0;
        rsp_push        = 1'b0;
        ram_cmd.rd_en   = 1'b0;
        ram_cmd.wr_en   = 1'b0;
        ram_cmd.rd_addr = iss_reg[IDX_W-1:0];
        ram_cmd.wr_addr = wr_idx_c;
        ram_cmd.wr_data = {key_reg, wr_refs_c};
        unique case (state_reg)
            ST_IDLE:  req_ready     = 1'b1;
            ST_SCAN:  ram_cmd.rd_en = (iss_reg != CNT_W'(TABLE_ENTRIES));
            ST_WRITE: ram_cmd.wr_en = wr_en_c;
            ST_DONE:  rsp_push      = rsp_free;
            default:  req_ready     = 1'b0;
        endcase
    end

    // Commit decision from the scan outcome
    always_comb
    begin
        refs_inc   = (hit_refs_reg == REF_MAX) ? hit_refs_reg : hit_refs_reg + REF_ONE;
        refs_dec   = (hit_refs_reg != '0) ? hit_refs_reg - REF_ONE : '0;
        wr_en_c    = 1'b0;
        wr_idx_c   = hit_idx_reg;
        wr_refs_c  = refs_inc;
        valid_next = valid_reg;
        total_next = total_reg;
        rsp_c      = '0;
        case (mode_reg)
            MODE_ADD:
            begin
                if (hit_reg)
                begin
                    wr_en_c     = 1'b1;
                    rsp_c.found = 1'b1;
                end
                else if (free_reg)
                begin
                    wr_en_c                = 1'b1;
                    wr_idx_c               = free_idx_reg;
                    wr_refs_c              = REF_ONE;
                    valid_next[free_idx_reg] = 1'b1;
                    total_next             = total_reg + CNT_W'(1);
                    rsp_c.found            = 1'b1;
                    rsp_c.flush_request    = 1'b1;
                end
                else
                begin
                    rsp_c.table_full = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (hit_reg)
                begin
                    rsp_c.found = 1'b1;
                    if ((refs_dec == '0) || force_reg)
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                        total_next = (total_reg != '0) ? total_reg - CNT_W'(1) : total_reg;
                        rsp_c.flush_request = 1'b1;
                    end
                    else
                    begin
                        wr_en_c   = 1'b1;
                        wr_refs_c = refs_dec;
                    end
                end
            end
            MODE_QUERY: rsp_c.found = hit_reg;
            default:
            begin
                valid_next = '0;
                total_next = '0;
            end
        endcase
        rsp_c.entry_count = OUT_CNT_W'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            total_reg   <= '0;
            iss_reg     <= '0;
            chk_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                iss_reg     <= '0;
                chk_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
            end
            if (state_reg == ST_SCAN)
            begin
                chk_vld_reg <= ram_cmd.rd_en;
                if (ram_cmd.rd_en)
                begin
                    iss_reg <= iss_reg + CNT_W'(1);
                end
                if (key_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (slot_free)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (state_reg == ST_WRITE)
            begin
                valid_reg <= valid_next;
                total_reg <= total_next;
            end
        end
    end

    // Payload: request word, first match and first free slot, result
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            mode_reg  <= mode_t'(req.mode);
            key_reg   <= req.page_dir_base;
            force_reg <= req.force_req;
        end
        if (state_reg == ST_SCAN)
        begin
            chk_idx_reg <= iss_reg[IDX_W-1:0];
            if (key_hit && !hit_reg)
            begin
                hit_idx_reg  <= chk_idx_reg;
                hit_refs_reg <= ram_rd_data[REF_BITS-1:0];
            end
            if (slot_free && !free_reg)
            begin
                free_idx_reg <= chk_idx_reg;
            end
        end
        if (state_reg == ST_WRITE)
        begin
            rsp_reg <= rsp_c;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== design/refcounted_key_membership_table.sv =====
// ----------------------------------------------------------------------------
// refcounted_key_membership_table
// Flow: a request is accepted in idle, the scan reads every entry through
//   the single read port of the entry RAM, the write state commits, and the
//   done state pushes the result word; a clear skips the scan. A new request
//   is taken only after the result has been pushed to the output register.
// Reset: asynchronous, active low; empties the table and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "refcounted_key_membership_table_defines.svh"

module refcounted_key_membership_table (
    input  logic        clk,
    input  logic        rst_n,
    rkmt_req_if.sink    req,
    rkmt_rsp_if.source  rsp
);
    import rkmt_pkg::*;

    // Keys and reference counts live in one RAM word per entry: {key, count}.
    // Valid bits and the entry total sit in flops inside the sequencer, so a
    // never-written RAM word is never trusted.
    req_t                req_word;
    ram_cmd_t            ram_cmd;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic                rsp_free;
    logic                rsp_push;
    rsp_t                rsp_word;

    logic                out_valid_reg;
    rsp_t                out_word_reg;

    // Pack the request channel into one word for the sequencer.
    assign req_word.mode          = req.mode;
    assign req_word.page_dir_base = req.page_dir_base;
    assign req_word.force_req     = req.force_req;

    rkmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_cmd.wr_en),
        .wr_addr (ram_cmd.wr_addr),
        .wr_data (ram_cmd.wr_data),
        .rd_en   (ram_cmd.rd_en),
        .rd_addr (ram_cmd.rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer: read every entry once, note the first key match and the
    // first free slot, then commit the update in the write state.
    rkmt_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req         (req_word),
        .req_ready   (req.ready),
        .ram_cmd     (ram_cmd),
        .ram_rd_data (ram_rd_data),
        .rsp_free    (rsp_free),
        .rsp_push    (rsp_push),
        .rsp         (rsp_word)
    );

    // Output register: hold the result word until the sink takes it; the
    // sequencer keeps accepting and scanning the next request meanwhile.
    assign rsp_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_push)
        begin
            out_word_reg <= rsp_word;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_word_reg.found;
    assign rsp.flush_request = out_word_reg.flush_request;
    assign rsp.table_full    = out_word_reg.table_full;
    assign rsp.entry_count   = out_word_reg.entry_count;

    // A result never overwrites a word the sink has not taken.
    `RKMT_ASSERT_IMP(a_push_into_free_slot, rsp_push, !out_valid_reg || rsp.ready)
    // One request at a time: after an accept the sequencer is busy.
    `RKMT_ASSERT_NXT(a_single_request, req.valid && req.ready, !req.ready)
    // A full table means nothing was inserted.
    `RKMT_ASSERT_IMP(a_full_excludes_hit, out_valid_reg && out_word_reg.table_full,
                     !out_word_reg.found && !out_word_reg.flush_request)
    // A flush only follows an insert or an erase of a present key.
    `RKMT_ASSERT_IMP(a_flush_implies_found, out_valid_reg && out_word_reg.flush_request,
                     out_word_reg.found)

endmodule

// ===== test/rkmt_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkmt_scoreboard
// Watches both channels of the key membership table. It keeps its own copy of
// the table and predicts one result word per accepted request. Each result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module rkmt_scoreboard (
    input  logic clk,
    input  logic rst_n,
    rkmt_req_if  req_mon,
    rkmt_rsp_if  rsp_mon,
    output int   mismatches,
    output int   outstanding,
    output int   results_seen,
    output int   flushes_seen,
    output int   full_seen
);
    import rkmt_pkg::*;

    logic                slot_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]    slot_key   [TABLE_ENTRIES];
    logic [REF_BITS-1:0] slot_refs  [TABLE_ENTRIES];
    int                  live_slots;
    rsp_t                pending_results [$];
    int                  n_mismatch;
    int                  n_results;
    int                  n_flush;
    int                  n_full;

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it causes.
    function automatic rsp_t predict_table_op(input mode_t m, input logic [KEY_W-1:0] key,
                                              input logic frc);
        rsp_t                r;
        int                  idx;
        logic [REF_BITS-1:0] left;
        r = '0;
        case (m)
            MODE_ADD:
            begin
                idx = find_slot(key);
                if (idx >= 0)
                begin
                    if (slot_refs[idx] != REF_MAX)
                        slot_refs[idx] = slot_refs[idx] + 1'b1;
                    r.found = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < TABLE_ENTRIES && idx < 0; i++)
                        if (!slot_valid[i])
                            idx = i;
                    if (idx >= 0)
                    begin
                        slot_valid[idx] = 1'b1;
                        slot_key[idx]   = key;
                        slot_refs[idx]  = REF_ONE;
                        live_slots++;
                        r.found         = 1'b1;
                        r.flush_request = 1'b1;
                    end
                    else
                        r.table_full = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                idx = find_slot(key);
                if (idx >= 0)
                begin
                    left = slot_refs[idx];
                    if (left != '0)
                        left = left - 1'b1;
                    if (left == '0 || frc)
                    begin
                        slot_valid[idx] = 1'b0;
                        slot_refs[idx]  = '0;
                        if (live_slots > 0)
                            live_slots--;
                        r.flush_request = 1'b1;
                    end
                    else
                        slot_refs[idx] = left;
                    r.found = 1'b1;
                end
            end
            MODE_QUERY:
                r.found = (find_slot(key) >= 0);
            default:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    slot_valid[i] = 1'b0;
                live_slots = 0;
            end
        endcase
        r.entry_count = OUT_CNT_W'(live_slots);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_mismatch < 40)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, n_results, what, got, want);
        n_mismatch++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_valid[i] = 1'b0;
            live_slots = 0;
            pending_results.delete();
            n_mismatch = 0;
            n_results  = 0;
            n_flush    = 0;
            n_full     = 0;
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                n_results++;
                if (rsp_mon.flush_request)
                    n_flush++;
                if (rsp_mon.table_full)
                    n_full++;
                if (pending_results.size() == 0)
                    report_mismatch("unrequested result word", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_mon.found !== want.found)
                        report_mismatch("found", rsp_mon.found, want.found);
                    if (rsp_mon.flush_request !== want.flush_request)
                        report_mismatch("flush_request", rsp_mon.flush_request,
                                        want.flush_request);
                    if (rsp_mon.table_full !== want.table_full)
                        report_mismatch("table_full", rsp_mon.table_full, want.table_full);
                    if (rsp_mon.entry_count !== want.entry_count)
                        report_mismatch("entry_count", rsp_mon.entry_count,
                                        want.entry_count);
                end
            end
            if (req_mon.valid && req_mon.ready)
                pending_results.push_back(predict_table_op(mode_t'(req_mon.mode),
                                                           req_mon.page_dir_base,
                                                           req_mon.force_req));
        end
        mismatches   <= n_mismatch;
        outstanding  <= pending_results.size();
        results_seen <= n_results;
        flushes_seen <= n_flush;
        full_seen    <= n_full;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression of the reference-counted key membership table. A directed pass
// walks insert, count up, count down, forced erase, fill to capacity and
// clear; then random requests over a small key pool run through four
// handshake phases with random idling, a long result hold-off and drain
// pauses. The scoreboard beside the block predicts and checks every word.
// ----------------------------------------------------------------------------

module testbench;
    import rkmt_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int POOL_KEYS    = 20;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 25;

    logic clk;
    logic rst_n;

    rkmt_req_if req_ch ();
    rkmt_rsp_if rsp_ch ();

    int mismatches;
    int outstanding;
    int results_seen;
    int flushes_seen;
    int full_seen;

    // Idling knobs, percent of cycles, set per phase by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long hold-off: the stimulus bumps hold_requests, the receiver serves it.
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int words_sent = 0;
    int quiet_cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_KEYS];

    refcounted_key_membership_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rkmt_scoreboard i_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .flushes_seen (flushes_seen),
        .full_seen    (full_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: stall at random, or hold off for a long stretch on request so
    // that the result register stays occupied and the block blocks its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: end the run when neither channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("refcounted_key_membership_table regression: fail");
                $finish;
            end
        end
    end

    // Offer one request word and hold it until the block takes it. Idle cycles
    // drop valid first; without a gap, valid stays high into the next word.
    task automatic send_word(input mode_t m, input logic [KEY_W-1:0] key, input logic frc);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= m;
        req_ch.page_dir_base <= key;
        req_ch.force_req     <= frc;
        do
            @(posedge clk);
        while (!req_ch.ready);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back. Wait on
    // the clock first so the count already includes the word just accepted.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly keys from the pool so that hits, refills and full tables happen;
    // now and then a fresh random key that will normally miss.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_KEYS - 1)];
        return {$urandom, $urandom};
    endfunction

    task automatic send_random_word();
        int   pick;
        mode_t m;
        logic frc;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            m = MODE_ADD;
        else if (pick < 72)
            m = MODE_REMOVE;
        else if (pick < 97)
            m = MODE_QUERY;
        else
            m = MODE_CLEAR;
        // Force only erases on a remove; keep it mostly off there so counts
        // can also drain down to zero one reference at a time.
        if (m == MODE_REMOVE)
            frc = ($urandom_range(0, 3) == 0);
        else
            frc = 1'($urandom_range(0, 1));
        send_word(m, pick_key(), frc);
    endtask

    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_ADD;
        req_ch.page_dir_base = '0;
        req_ch.force_req     = 1'b0;
        rsp_ch.ready         = 1'b0;
        rst_n                = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the key space sit at the head of the pool.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = {$urandom, $urandom};

        // Directed: remove on an empty table, count a key up to three, step
        // down once, then force the erase while a reference is still left.
        send_word(MODE_REMOVE, key_pool[0], 1'b0);
        send_word(MODE_ADD,    key_pool[0], 1'b1);
        send_word(MODE_ADD,    key_pool[0], 1'b0);
        send_word(MODE_ADD,    key_pool[0], 1'b1);
        send_word(MODE_REMOVE, key_pool[0], 1'b0);
        send_word(MODE_REMOVE, key_pool[0], 1'b1);
        // Insert the all-ones key and erase it by its count reaching zero.
        send_word(MODE_ADD,    key_pool[1], 1'b0);
        send_word(MODE_REMOVE, key_pool[1], 1'b0);
        // Fill every slot, then add one more key against a full table.
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_word(MODE_ADD, key_pool[i], i[0]);
        send_word(MODE_ADD, key_pool[TABLE_ENTRIES], 1'b1);
        // Empty the table without a flush.
        send_word(MODE_CLEAR, key_pool[1], 1'b1);
        wait_for_results();

        // Random: no idling, sender idling, receiver stalling, then both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                    // Hold off the receiver while the sender keeps offering.
                    hold_requests = hold_requests + 1;
                end
                default:
                begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                if (n == RANDOM_ITEMS / 8)
                    wait_for_results();
                send_random_word();
            end
        end

        // Drain: let every prediction be matched, then watch for strays.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d flushes, %0d table-full adds",
                 words_sent, results_seen, flushes_seen, full_seen);
        $display("four handshake phases, one long result hold-off, drain pauses per phase");
        if (mismatches == 0 && outstanding == 0)
            $display("refcounted_key_membership_table regression: pass");
        else
            $display("refcounted_key_membership_table regression: fail");
        $finish;
    end

endmodule
